FILE: hw/rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Holds operation, status and multiplier-select codes and the command/status structs.
// No dependencies.
package rau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam int WIDE_BITS = 64;
    localparam int CNT_BITS  = 6;

    typedef enum logic [1:0] {
        MS_FIRST  = 2'd0,
        MS_SECOND = 2'd1,
        MS_THIRD  = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     comb;
        logic     gcd_step;
        logic     shift;
        logic     div_step;
        logic     out_load;
    } rau_cmd_t;

    typedef struct packed {
        logic special;
        logic gcd_done;
        logic div_last;
    } rau_stat_t;

endpackage

FILE: hw/rtl/rau_ctrl.sv
// Controller state machine for the rational arithmetic unit.
// Sequences multiply, combine, GCD, shift and divide steps; owns the output valid.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rau_pkg::rau_stat_t stat,
    output rau_pkg::rau_cmd_t  cmd
);
    import rau_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MUL0  = 9'b000000010,
        S_MUL1  = 9'b000000100,
        S_MUL2  = 9'b000001000,
        S_COMB  = 9'b000010000,
        S_GCD   = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_DIV   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MS_FIRST;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_FIRST;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_SECOND;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_THIRD;
                state_next  = S_COMB;
            end
            S_COMB:
            begin
                cmd.comb   = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (stat.special)
                begin
                    state_next = S_DONE;
                end
                else if (stat.gcd_done)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while a transaction waits");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL0))
        else $error("accepted transaction did not start the multiply sequence");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");

endmodule

FILE: hw/rtl/rau_datapath.sv
// Datapath for the rational arithmetic unit: shared multiplier, combine adder,
// binary GCD engine, dual restoring divider and output register. Depends on rau_pkg.
module rau_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  rau_pkg::rau_cmd_t   cmd,
    output rau_pkg::rau_stat_t  stat,
    input  logic [1:0]          req_type,
    input  logic signed [31:0]  a_num,
    input  logic [30:0]         a_den,
    input  logic signed [31:0]  b_num,
    input  logic [30:0]         b_den,
    output logic signed [31:0]  res_num,
    output logic [30:0]         res_den,
    output logic [1:0]          status
);
    import rau_pkg::*;

    localparam logic [WIDE_BITS-1:0] LIM = WIDE_BITS'(1) << (VALUE_BITS - 1);

    logic [1:0]            op_reg;
    logic [31:0]           am_reg, bm_reg;
    logic [30:0]           ad_reg, bd_reg;
    logic                  an_reg, bn_reg, err_reg;
    logic [WIDE_BITS-1:0]  m0_reg, m1_reg, m2_reg;
    logic [WIDE_BITS-1:0]  nm_reg, dm_reg, nm_next;
    logic                  neg_reg, neg_next;
    logic [WIDE_BITS-1:0]  u_reg, v_reg, g_reg;
    logic [CNT_BITS-1:0]   k_reg, cnt_reg;
    logic [WIDE_BITS:0]    rn_reg, rd_reg;
    logic [WIDE_BITS-1:0]  qn_reg, qd_reg;
    logic signed [31:0]    res_num_reg;
    logic [30:0]           res_den_reg;
    logic [1:0]            status_reg;

    logic [31:0]           mul_a, mul_b;
    logic [WIDE_BITS-1:0]  prod;
    logic                  qneg;
    logic [WIDE_BITS:0]    rn_sh, rd_sh, g_ext;
    logic                  ovf;
    logic [31:0]           mag_low;

    // operand multiplexer for the shared multiplier
    always_comb
    begin
        mul_a = am_reg;
        mul_b = {1'b0, bd_reg};
        case (cmd.mul_sel)
            MS_FIRST:
            begin
                mul_a = am_reg;
                mul_b = (op_reg == OP_MUL) ? bm_reg : {1'b0, bd_reg};
            end
            MS_SECOND:
            begin
                mul_a = bm_reg;
                mul_b = {1'b0, ad_reg};
            end
            default:
            begin
                mul_a = {1'b0, ad_reg};
                mul_b = (op_reg == OP_DIV) ? bm_reg : {1'b0, bd_reg};
            end
        endcase
        prod = WIDE_BITS'(mul_a) * WIDE_BITS'(mul_b);
    end

    // combine cross products and settle the sign
    always_comb
    begin
        qneg     = (op_reg == OP_SUB) ? !bn_reg : bn_reg;
        nm_next  = m0_reg;
        neg_next = an_reg != bn_reg;
        if (op_reg == OP_ADD || op_reg == OP_SUB)
        begin
            if (an_reg == qneg)
            begin
                nm_next  = m0_reg + m1_reg;
                neg_next = an_reg;
            end
            else if (m0_reg >= m1_reg)
            begin
                nm_next  = m0_reg - m1_reg;
                neg_next = an_reg;
            end
            else
            begin
                nm_next  = m1_reg - m0_reg;
                neg_next = qneg;
            end
        end
    end

    assign g_ext = {1'b0, g_reg};
    assign rn_sh = {rn_reg[WIDE_BITS-1:0], qn_reg[WIDE_BITS-1]};
    assign rd_sh = {rd_reg[WIDE_BITS-1:0], qd_reg[WIDE_BITS-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req_type;
            an_reg  <= a_num[31];
            bn_reg  <= b_num[31];
            am_reg  <= a_num[31] ? (32'd0 - a_num) : a_num;
            bm_reg  <= b_num[31] ? (32'd0 - b_num) : b_num;
            ad_reg  <= a_den;
            bd_reg  <= b_den;
            err_reg <= (a_den == '0) || (b_den == '0) ||
                       (req_type == OP_DIV && b_num == '0);
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MS_FIRST:  m0_reg <= prod;
                MS_SECOND: m1_reg <= prod;
                default:   m2_reg <= prod;
            endcase
        end
        if (cmd.comb)
        begin
            nm_reg  <= nm_next;
            dm_reg  <= m2_reg;
            neg_reg <= neg_next;
            u_reg   <= nm_next;
            v_reg   <= m2_reg;
            k_reg   <= '0;
        end
        if (cmd.gcd_step)
        begin
            if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end
        if (cmd.shift)
        begin
            g_reg   <= (u_reg | v_reg) << k_reg;
            rn_reg  <= '0;
            rd_reg  <= '0;
            qn_reg  <= nm_reg;
            qd_reg  <= dm_reg;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (rn_sh >= g_ext)
            begin
                rn_reg <= rn_sh - g_ext;
                qn_reg <= {qn_reg[WIDE_BITS-2:0], 1'b1};
            end
            else
            begin
                rn_reg <= rn_sh;
                qn_reg <= {qn_reg[WIDE_BITS-2:0], 1'b0};
            end
            if (rd_sh >= g_ext)
            begin
                rd_reg <= rd_sh - g_ext;
                qd_reg <= {qd_reg[WIDE_BITS-2:0], 1'b1};
            end
            else
            begin
                rd_reg <= rd_sh;
                qd_reg <= {qd_reg[WIDE_BITS-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            if (err_reg)
            begin
                res_num_reg <= '0;
                res_den_reg <= 31'd1;
                status_reg  <= ST_DIV0;
            end
            else if (nm_reg == '0)
            begin
                res_num_reg <= '0;
                res_den_reg <= 31'd1;
                status_reg  <= ST_OK;
            end
            else if (ovf)
            begin
                res_num_reg <= '0;
                res_den_reg <= 31'd1;
                status_reg  <= ST_OVF;
            end
            else
            begin
                res_num_reg <= neg_reg ? (32'd0 - mag_low) : mag_low;
                res_den_reg <= qd_reg[30:0];
                status_reg  <= ST_OK;
            end
        end
    end

    assign mag_low = qn_reg[31:0];
    assign ovf     = (qd_reg >= LIM) || (neg_reg ? (qn_reg > LIM) : (qn_reg >= LIM));

    assign stat.special  = err_reg || (nm_reg == '0);
    assign stat.gcd_done = (u_reg == '0) || (v_reg == '0);
    assign stat.div_last = (cnt_reg == {CNT_BITS{1'b1}});

    assign res_num = res_num_reg;
    assign res_den = res_den_reg;
    assign status  = status_reg;

endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: joins controller and datapath.
// Depends on rau_pkg, rau_ctrl and rau_datapath.
//
// Takes one transaction of two fractions and an operation (add, subtract,
// multiply, divide) and returns the exactly computed, fully reduced result
// with a status: ok, division by a zero fraction (or a zero denominator given),
// or overflow of the VALUE_BITS result range. A zero result comes back as 0/1.
// One transaction is worked at a time: the shared 32x32 multiplier forms the
// products in turn, then follow a combine step, the binary GCD loop (one step
// per cycle, for 64-bit intermediates), a shift step, the bit-serial exact
// divider and the load of the output register. The next transaction can be
// accepted in the same cycle as the result becomes valid; error and zero
// results skip the GCD and divide. The next transaction is accepted while a
// finished result still waits on the output side; a second finished result
// holds in the controller until the output register is free, and input
// stalls meanwhile.
module rational_arithmetic_unit #(
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] a_num,
    input  logic [30:0]        a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0]        b_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] res_num,
    output logic [30:0]        res_den,
    output logic [1:0]         status
);
    import rau_pkg::*;

    rau_cmd_t  cmd;
    rau_stat_t stat;

    // sequence the steps of each transaction
    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic, GCD reduction and output register
    rau_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .stat     (stat),
        .req_type (req_type),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .res_num  (res_num),
        .res_den  (res_den),
        .status   (status)
    );

endmodule
